// ----- design/assert_macros.svh -----
// Assertion helpers used by the matrix builder back end.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/kmb_pkg.sv -----
// Shared types, constants and the back-end step program for the transition matrix builder.
// No dependencies.
package kmb_pkg;

  localparam int Q30W = 34;
  localparam int PROD_W = 2 * Q30W;
  localparam int DIVW = Q30W + 16;
  localparam int CNT_W = $clog2(DIVW + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [Q30W-1:0] q30_t;

  localparam q30_t CORDIC_GAIN = 34'sd652032874;
  localparam q30_t PI_Q30 = 34'sd3373259426;
  localparam q30_t HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    q30_t sr;
    q30_t cr;
    q30_t sp;
    q30_t cp;
    q30_t sy;
    q30_t cy;
    q30_t dt;
  } trig_t;

  typedef struct packed {
    q30_t sr;
    q30_t cr;
    q30_t sp;
    q30_t cp;
    q30_t sy;
    q30_t cy;
    q30_t dt;
    q30_t spsr;
    q30_t spcr;
    q30_t t0;
    q30_t t1;
    q30_t v0;
    q30_t v1;
    q30_t v2;
  } bank_t;

  typedef enum logic [3:0] {
    R_SR, R_CR, R_SP, R_CP, R_SY, R_CY, R_DT,
    R_SPSR, R_SPCR, R_T0, R_T1, R_V0, R_V1, R_V2
  } reg_sel_t;

  typedef enum logic [1:0] {C_PASS, C_ADD, C_SUB, C_NEG} comb_t;

  // K_MUL writes a register, the others produce one matrix entry.
  typedef enum logic [1:0] {K_MUL, K_EQ, K_EA, K_ES} kind_t;

  typedef enum logic [1:0] {BK_IDLE, BK_RUN, BK_DIV} bk_state_t;

  typedef struct packed {
    kind_t    kind;
    reg_sel_t ra;
    reg_sel_t rb;
    comb_t    comb;
    reg_sel_t rc;
    reg_sel_t dest;
    logic [3:0] row;
    logic [3:0] col;
  } step_t;

  localparam int STEP_COUNT = 57;
  localparam int PC_W = $clog2(STEP_COUNT);
  localparam logic [PC_W-1:0] LAST_PC = PC_W'(STEP_COUNT - 1);

  function automatic q30_t atan_q30(input logic [4:0] i);
    q30_t r;
    case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q30_t pick(input bank_t b, input reg_sel_t s);
    q30_t r;
    case (s)
      R_SR:   r = b.sr;
      R_CR:   r = b.cr;
      R_SP:   r = b.sp;
      R_CP:   r = b.cp;
      R_SY:   r = b.sy;
      R_CY:   r = b.cy;
      R_DT:   r = b.dt;
      R_SPSR: r = b.spsr;
      R_SPCR: r = b.spcr;
      R_T0:   r = b.t0;
      R_T1:   r = b.t1;
      R_V0:   r = b.v0;
      R_V1:   r = b.v1;
      R_V2:   r = b.v2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic step_t mul_op(input reg_sel_t dest, input reg_sel_t ra,
                                   input comb_t comb, input reg_sel_t rb,
                                   input reg_sel_t rc);
    step_t s;
    s.kind = K_MUL;
    s.ra = ra;
    s.rb = rb;
    s.comb = comb;
    s.rc = rc;
    s.dest = dest;
    s.row = 4'd0;
    s.col = 4'd0;
    return s;
  endfunction

  function automatic step_t emit_op(input kind_t k, input reg_sel_t ra,
                                    input logic [3:0] row, input logic [3:0] col);
    step_t s;
    s.kind = k;
    s.ra = ra;
    s.rb = ra;
    s.comb = C_PASS;
    s.rc = R_DT;
    s.dest = R_V0;
    s.row = row;
    s.col = col;
    return s;
  endfunction

  // Run once per item by the back end: products precede their entries, entries in output order.
  function automatic step_t step_at(input logic [PC_W-1:0] pc);
    step_t s;
    case (pc)
      6'd0:  s = mul_op(R_SPSR, R_SP, C_PASS, R_SP, R_SR);
      6'd1:  s = mul_op(R_SPCR, R_SP, C_PASS, R_SP, R_CR);
      6'd2:  s = mul_op(R_T0, R_CY, C_PASS, R_CY, R_CP);
      6'd3:  s = mul_op(R_V0, R_T0, C_PASS, R_T0, R_DT);
      6'd4:  s = mul_op(R_T0, R_CY, C_PASS, R_CY, R_SPSR);
      6'd5:  s = mul_op(R_T1, R_SY, C_PASS, R_SY, R_CR);
      6'd6:  s = mul_op(R_V1, R_T0, C_SUB, R_T1, R_DT);
      6'd7:  s = mul_op(R_T0, R_CY, C_PASS, R_CY, R_SPCR);
      6'd8:  s = mul_op(R_T1, R_SY, C_PASS, R_SY, R_SR);
      6'd9:  s = mul_op(R_V2, R_T0, C_ADD, R_T1, R_DT);
      6'd10: s = emit_op(K_EQ, R_V0, 4'd0, 4'd6);
      6'd11: s = emit_op(K_EQ, R_V1, 4'd0, 4'd7);
      6'd12: s = emit_op(K_EQ, R_V2, 4'd0, 4'd8);
      6'd13: s = emit_op(K_EA, R_V0, 4'd0, 4'd12);
      6'd14: s = emit_op(K_EA, R_V1, 4'd0, 4'd13);
      6'd15: s = emit_op(K_EA, R_V2, 4'd0, 4'd14);
      6'd16: s = mul_op(R_T0, R_SY, C_PASS, R_SY, R_CP);
      6'd17: s = mul_op(R_V0, R_T0, C_PASS, R_T0, R_DT);
      6'd18: s = mul_op(R_T0, R_SY, C_PASS, R_SY, R_SPSR);
      6'd19: s = mul_op(R_T1, R_CY, C_PASS, R_CY, R_CR);
      6'd20: s = mul_op(R_V1, R_T0, C_ADD, R_T1, R_DT);
      6'd21: s = mul_op(R_T0, R_SY, C_PASS, R_SY, R_SPCR);
      6'd22: s = mul_op(R_T1, R_CY, C_PASS, R_CY, R_SR);
      6'd23: s = mul_op(R_V2, R_T0, C_SUB, R_T1, R_DT);
      6'd24: s = emit_op(K_EQ, R_V0, 4'd1, 4'd6);
      6'd25: s = emit_op(K_EQ, R_V1, 4'd1, 4'd7);
      6'd26: s = emit_op(K_EQ, R_V2, 4'd1, 4'd8);
      6'd27: s = emit_op(K_EA, R_V0, 4'd1, 4'd12);
      6'd28: s = emit_op(K_EA, R_V1, 4'd1, 4'd13);
      6'd29: s = emit_op(K_EA, R_V2, 4'd1, 4'd14);
      6'd30: s = mul_op(R_V0, R_SP, C_NEG, R_SP, R_DT);
      6'd31: s = mul_op(R_T0, R_CP, C_PASS, R_CP, R_SR);
      6'd32: s = mul_op(R_V1, R_T0, C_PASS, R_T0, R_DT);
      6'd33: s = mul_op(R_T0, R_CP, C_PASS, R_CP, R_CR);
      6'd34: s = mul_op(R_V2, R_T0, C_PASS, R_T0, R_DT);
      6'd35: s = emit_op(K_EQ, R_V0, 4'd2, 4'd6);
      6'd36: s = emit_op(K_EQ, R_V1, 4'd2, 4'd7);
      6'd37: s = emit_op(K_EQ, R_V2, 4'd2, 4'd8);
      6'd38: s = emit_op(K_EA, R_V0, 4'd2, 4'd12);
      6'd39: s = emit_op(K_EA, R_V1, 4'd2, 4'd13);
      6'd40: s = emit_op(K_EA, R_V2, 4'd2, 4'd14);
      6'd41: s = emit_op(K_EQ, R_DT, 4'd3, 4'd9);
      6'd42: s = mul_op(R_V0, R_SPSR, C_PASS, R_SPSR, R_DT);
      6'd43: s = emit_op(K_ES, R_V0, 4'd3, 4'd10);
      6'd44: s = mul_op(R_V0, R_SPCR, C_PASS, R_SPCR, R_DT);
      6'd45: s = emit_op(K_ES, R_V0, 4'd3, 4'd11);
      6'd46: s = mul_op(R_V0, R_CR, C_PASS, R_CR, R_DT);
      6'd47: s = emit_op(K_EQ, R_V0, 4'd4, 4'd10);
      6'd48: s = mul_op(R_V0, R_SR, C_NEG, R_SR, R_DT);
      6'd49: s = emit_op(K_EQ, R_V0, 4'd4, 4'd11);
      6'd50: s = mul_op(R_V0, R_SR, C_PASS, R_SR, R_DT);
      6'd51: s = emit_op(K_ES, R_V0, 4'd5, 4'd10);
      6'd52: s = mul_op(R_V0, R_CR, C_PASS, R_CR, R_DT);
      6'd53: s = emit_op(K_ES, R_V0, 4'd5, 4'd11);
      6'd54: s = emit_op(K_EQ, R_DT, 4'd6, 4'd12);
      6'd55: s = emit_op(K_EQ, R_DT, 4'd7, 4'd13);
      6'd56: s = emit_op(K_EQ, R_DT, 4'd8, 4'd14);
      default: s = emit_op(K_EQ, R_DT, 4'd8, 4'd14);
    endcase
    return s;
  endfunction

endpackage

// ----- design/kmb_cordic.sv -----
// Iterative CORDIC producing sine and cosine of one Q3.13 angle in Q4.30.
// Depends on kmb_pkg.
module kmb_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               busy,
  output kmb_pkg::q30_t      sin_q,
  output kmb_pkg::q30_t      cos_q
);

  localparam int IW = $clog2(TRIG_ITERATIONS);

  kmb_pkg::q30_t x;
  kmb_pkg::q30_t y;
  kmb_pkg::q30_t z;
  kmb_pkg::q30_t z_in;
  logic          neg;
  logic [IW-1:0] iter;

  assign z_in = kmb_pkg::q30_t'(angle) <<< 17;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (iter == IW'(TRIG_ITERATIONS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= kmb_pkg::CORDIC_GAIN;
      y <= '0;
      // Fold the angle into the half circle that CORDIC converges on.
      if (z_in > kmb_pkg::HALF_PI_Q30) begin
        z   <= z_in - kmb_pkg::PI_Q30;
        neg <= 1'b1;
      end else if (z_in < -kmb_pkg::HALF_PI_Q30) begin
        z   <= z_in + kmb_pkg::PI_Q30;
        neg <= 1'b1;
      end else begin
        z   <= z_in;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (!z[kmb_pkg::Q30W-1]) begin
        x <= x - (y >>> iter);
        y <= y + (x >>> iter);
        z <= z - kmb_pkg::atan_q30(5'(iter));
      end else begin
        x <= x + (y >>> iter);
        y <= y - (x >>> iter);
        z <= z + kmb_pkg::atan_q30(5'(iter));
      end
    end
  end

  assign sin_q = neg ? -y : y;
  assign cos_q = neg ? -x : x;

endmodule

// ----- design/kmb_front.sv -----
// Front end: accepts attitude and step items and forms sines, cosines and the Q4.30 step.
// Depends on kmb_pkg and kmb_cordic.
module kmb_front #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  input  logic [15:0]        step_time,
  output logic               push,
  output kmb_pkg::trig_t     push_data,
  input  logic               q_full
);

  logic          pending;
  logic          start;
  logic [2:0]    busy;
  kmb_pkg::q30_t dt;

  assign in_stall = pending;
  assign start    = in_valid && !pending;
  assign push     = pending && (busy == 3'b000) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (start) begin
      pending <= 1'b1;
    end else if (push) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dt <= kmb_pkg::q30_t'({step_time, 14'b0});
    end
  end

  kmb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_roll (
    .clk(clk), .rst(rst), .start(start), .angle(roll),
    .busy(busy[0]), .sin_q(push_data.sr), .cos_q(push_data.cr)
  );

  kmb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_pitch (
    .clk(clk), .rst(rst), .start(start), .angle(pitch),
    .busy(busy[1]), .sin_q(push_data.sp), .cos_q(push_data.cp)
  );

  kmb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_yaw (
    .clk(clk), .rst(rst), .start(start), .angle(yaw),
    .busy(busy[2]), .sin_q(push_data.sy), .cos_q(push_data.cy)
  );

  assign push_data.dt = dt;

endmodule

// ----- design/kmb_queue.sv -----
// Two-entry queue of trigonometric records between the front and back ends.
// Depends on kmb_pkg.
module kmb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kmb_pkg::trig_t push_data,
  output logic           full,
  input  logic           pop,
  output kmb_pkg::trig_t pop_data,
  output logic           not_empty
);

  localparam int AW = $clog2(kmb_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(kmb_pkg::QUEUE_DEPTH + 1);

  kmb_pkg::trig_t mem [kmb_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(kmb_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- design/kmb_back.sv -----
// Back end: runs the step program on one shared multiplier and a serial divider,
// and delivers the 28 matrix entries through an output register. Depends on kmb_pkg.
`include "assert_macros.svh"

module kmb_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          trig_valid,
  input  kmb_pkg::trig_t                trig,
  output logic                          trig_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    row,
  output logic [3:0]                    column,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          saturated,
  output logic                          last
);

  localparam int QW = kmb_pkg::Q30W;
  localparam int DW = kmb_pkg::DIVW;
  localparam int CW = kmb_pkg::CNT_W;
  localparam int PW = kmb_pkg::PROD_W;
  localparam logic [DW-1:0] MAG_POS = DW'(64'd1 << (VALUE_WIDTH - 1)) - DW'(1);
  localparam logic [DW-1:0] MAG_NEG = DW'(64'd1 << (VALUE_WIDTH - 1));
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  kmb_pkg::bk_state_t state;
  kmb_pkg::bk_state_t state_next;
  logic [kmb_pkg::PC_W-1:0] pc;
  kmb_pkg::bank_t bank;
  kmb_pkg::step_t step;

  kmb_pkg::q30_t opa_r;
  kmb_pkg::q30_t opb_r;
  kmb_pkg::q30_t opa;
  kmb_pkg::q30_t opm;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r30;
  logic signed [PW-1:0] prod_r31;
  kmb_pkg::q30_t mul30_res;
  kmb_pkg::q30_t mul31_res;
  kmb_pkg::q30_t emit_src;
  kmb_pkg::q30_t emit_q16;
  logic signed [VALUE_WIDTH-1:0] emit_val;

  logic          num_neg;
  logic [QW-1:0] num_mag;
  logic [QW-1:0] cp_mag;

  logic [DW-1:0] qd;
  logic [QW:0]   rem;
  logic [QW-1:0] dsr;
  logic          q_neg;
  logic [CW-1:0] cnt;
  logic [QW:0]   rem_sh;
  logic [QW:0]   diff;
  logic          div_sat;
  logic signed [VALUE_WIDTH-1:0] div_val;

  logic out_free;
  logic emit;
  logic signed [VALUE_WIDTH-1:0] e_val;
  logic e_sat;
  logic div_start;
  logic div_step;
  logic advance;
  logic mul_wr;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    step  = kmb_pkg::step_at(pc);
    opa_r = kmb_pkg::pick(bank, step.ra);
    opb_r = kmb_pkg::pick(bank, step.rb);
    unique case (step.comb)
      kmb_pkg::C_PASS: opa = opa_r;
      kmb_pkg::C_ADD:  opa = opa_r + opb_r;
      kmb_pkg::C_SUB:  opa = opa_r - opb_r;
      kmb_pkg::C_NEG:  opa = -opa_r;
    endcase
    opm = (step.kind == kmb_pkg::K_EA) ? bank.dt : kmb_pkg::pick(bank, step.rc);
  end

  assign prod      = PW'(opa) * PW'(opm);
  assign prod_r30  = (prod + (PW'(1) <<< 29)) >>> 30;
  assign prod_r31  = (prod + (PW'(1) <<< 30)) >>> 31;
  assign mul30_res = kmb_pkg::q30_t'(prod_r30);
  assign mul31_res = kmb_pkg::q30_t'(prod_r31);
  assign emit_src  = (step.kind == kmb_pkg::K_EA) ? mul31_res : opa;
  assign emit_q16  = (emit_src + kmb_pkg::q30_t'(1 << 13)) >>> 14;
  assign emit_val  = VALUE_WIDTH'(emit_q16);

  assign num_neg = opa[QW-1];
  assign num_mag = num_neg ? QW'(-opa) : QW'(opa);
  assign cp_mag  = bank.cp[QW-1] ? QW'(-bank.cp) : QW'(bank.cp);

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_sh = {rem[QW-1:0], qd[DW-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_comb begin
    if (!q_neg) begin
      div_sat = (qd > MAG_POS);
      div_val = div_sat ? VMAX : VALUE_WIDTH'(qd);
    end else begin
      div_sat = (qd > MAG_NEG);
      div_val = div_sat ? VMIN : -VALUE_WIDTH'(qd);
    end
  end

  always_comb begin
    state_next = state;
    trig_pop   = 1'b0;
    emit       = 1'b0;
    e_val      = emit_val;
    e_sat      = 1'b0;
    div_start  = 1'b0;
    div_step   = 1'b0;
    advance    = 1'b0;
    mul_wr     = 1'b0;
    unique case (state)
      kmb_pkg::BK_IDLE: begin
        if (trig_valid) begin
          trig_pop   = 1'b1;
          state_next = kmb_pkg::BK_RUN;
        end
      end
      kmb_pkg::BK_RUN: begin
        unique case (step.kind)
          kmb_pkg::K_MUL: begin
            mul_wr  = 1'b1;
            advance = 1'b1;
          end
          kmb_pkg::K_EQ, kmb_pkg::K_EA: begin
            if (out_free) begin
              emit    = 1'b1;
              advance = 1'b1;
            end
          end
          kmb_pkg::K_ES: begin
            if (bank.cp == '0) begin
              // A zero cosine gives zero for a zero numerator and a clipped value otherwise.
              if (out_free) begin
                emit    = 1'b1;
                advance = 1'b1;
                e_sat   = (opa != '0);
                if (opa == '0) begin
                  e_val = '0;
                end else begin
                  e_val = num_neg ? VMIN : VMAX;
                end
              end
            end else begin
              div_start  = 1'b1;
              state_next = kmb_pkg::BK_DIV;
            end
          end
        endcase
      end
      kmb_pkg::BK_DIV: begin
        if (cnt != CW'(DW)) begin
          div_step = 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          e_val      = div_val;
          e_sat      = div_sat;
          advance    = 1'b1;
          state_next = kmb_pkg::BK_RUN;
        end
      end
      default: state_next = kmb_pkg::BK_IDLE;
    endcase
    if (advance && pc == kmb_pkg::LAST_PC) begin
      state_next = kmb_pkg::BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmb_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (trig_pop) begin
      pc <= '0;
    end else if (advance) begin
      pc <= pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (trig_pop) begin
      bank.sr <= trig.sr;
      bank.cr <= trig.cr;
      bank.sp <= trig.sp;
      bank.cp <= trig.cp;
      bank.sy <= trig.sy;
      bank.cy <= trig.cy;
      bank.dt <= trig.dt;
    end
    if (mul_wr) begin
      case (step.dest)
        kmb_pkg::R_SPSR: bank.spsr <= mul30_res;
        kmb_pkg::R_SPCR: bank.spcr <= mul30_res;
        kmb_pkg::R_T0:   bank.t0 <= mul30_res;
        kmb_pkg::R_T1:   bank.t1 <= mul30_res;
        kmb_pkg::R_V0:   bank.v0 <= mul30_res;
        kmb_pkg::R_V1:   bank.v1 <= mul30_res;
        kmb_pkg::R_V2:   bank.v2 <= mul30_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (div_start) begin
      cnt <= '0;
    end else if (div_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      qd    <= {num_mag, 16'b0};
      rem   <= '0;
      dsr   <= cp_mag;
      q_neg <= num_neg ^ bank.cp[QW-1];
    end else if (div_step) begin
      if (!diff[QW]) begin
        rem <= diff;
        qd  <= {qd[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        qd  <= {qd[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row       <= step.row;
      column    <= step.col;
      value     <= e_val;
      saturated <= e_sat;
      last      <= (pc == kmb_pkg::LAST_PC);
    end
  end

  `ASSERT_CLK(a_last_entry, out_valid && last |-> row == 4'd8 && column == 4'd14, "last flag on wrong entry")
  `ASSERT_CLK(a_pc_range, state != kmb_pkg::BK_IDLE |-> pc <= kmb_pkg::LAST_PC, "program counter out of range")
  `ASSERT_NEVER(a_div_cnt, state == kmb_pkg::BK_DIV && cnt > CW'(DW), "divider overran its bit count")

endmodule

// ----- design/kinematic_transition_matrix_builder_top.sv -----
// Top level of the transition matrix builder: front end, queue and back end.
// Depends on kmb_pkg, kmb_front, kmb_queue and kmb_back.
//
// Input channel (in_valid / in_stall) carries roll, pitch, yaw (Q3.13) and step_time
// (Q0.16). Output channel (out_valid / out_stall) carries 28 entries per item, each a
// row, a column, a Q16.16 value, a saturated flag and last on the 28th entry.
// The front end takes an item, runs three CORDIC units and hands the result to a
// two-entry queue; it takes the next item as soon as that transfer is done.
// The back end works one item at a time: it takes the item from the queue, then runs
// 29 multiply steps, 24 direct entries and four secant entries that each wait on a
// serial divide. Its time per item sets the sustained rate.
// A stalled receiver holds the output register; the back end then waits on its next
// entry while the front end and queue keep taking up to three items.
// Synchronous reset empties the queue and returns both ends to idle; no entry is lost
// or repeated outside reset.
module kinematic_transition_matrix_builder_top #(
  parameter int VALUE_WIDTH     = 32,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            roll,
  input  logic signed [15:0]            pitch,
  input  logic signed [15:0]            yaw,
  input  logic [15:0]                   step_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    row,
  output logic [3:0]                    column,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          saturated,
  output logic                          last
);

  logic           push;
  logic           q_full;
  logic           pop;
  logic           not_empty;
  kmb_pkg::trig_t push_data;
  kmb_pkg::trig_t pop_data;

  kmb_front #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .roll(roll), .pitch(pitch), .yaw(yaw), .step_time(step_time),
    .push(push), .push_data(push_data), .q_full(q_full)
  );

  kmb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .pop_data(pop_data), .not_empty(not_empty)
  );

  kmb_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .trig_valid(not_empty), .trig(pop_data), .trig_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .row(row), .column(column),
    .value(value), .saturated(saturated), .last(last)
  );

endmodule

// ----- tb/sv/kinematic_transition_matrix_builder_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for kinematic_transition_matrix_builder_top.
// Depends on kmb_pkg and the builder RTL; predicts all 28 entries per item in fixed point.
module kinematic_transition_matrix_builder_top_tb;

  localparam int VW = 32;
  localparam int ITERS = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_ITEMS = 40;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam logic signed [15:0] PITCH_UP = 16'sd12868;

  typedef enum logic [1:0] {BY_MODEL, ALL_ZERO, STEP_ENTRIES} known_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [15:0] dt;
    known_t known;
  } attitude_row_t;

  typedef struct {
    logic [3:0] row;
    logic [3:0] col;
    logic signed [VW-1:0] value;
    logic sat;
    logic last;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] roll = '0, pitch = '0, yaw = '0;
  logic [15:0] step_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] row, column;
  logic signed [VW-1:0] value;
  logic saturated, last;

  entry_t entries_due[$];
  int entry_index;
  int mismatches = 0;
  int items_taken = 0;
  int entries_seen = 0;
  int sat_seen = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  const attitude_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'd0, ALL_ZERO},
    '{16'sd0, 16'sd0, 16'sd0, 16'hFFFF, STEP_ENTRIES},
    '{16'sd0, 16'sd0, 16'sd0, 16'd1, STEP_ENTRIES},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0, ALL_ZERO},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF, STEP_ENTRIES},
    '{16'sh7FFF, -16'sd32768, 16'sh7FFF, 16'h8000, BY_MODEL},
    '{16'sd6434, PITCH_UP, 16'sd0, 16'hFFFF, BY_MODEL},
    '{16'sd6434, PITCH_UP - 16'sd1, 16'sd3000, 16'hFFFF, BY_MODEL},
    '{-16'sd6434, PITCH_UP + 16'sd1, -16'sd3000, 16'hFFFF, BY_MODEL},
    '{16'sd100, -PITCH_UP, 16'sd100, 16'hFFFF, BY_MODEL},
    '{-16'sd100, -PITCH_UP + 16'sd2, 16'sd200, 16'h4000, BY_MODEL},
    '{16'sd0, PITCH_UP, 16'sd0, 16'd0, ALL_ZERO},
    '{16'sd12868, 16'sd4000, -16'sd12868, 16'h1234, BY_MODEL},
    '{-16'sd25736, 16'sd25736, 16'sd25735, 16'hABCD, BY_MODEL},
    '{16'sd8192, -16'sd8192, 16'sd16384, 16'h0100, BY_MODEL}
  };

  kinematic_transition_matrix_builder_top #(.VALUE_WIDTH(VW), .TRIG_ITERATIONS(ITERS)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .roll(roll), .pitch(pitch), .yaw(yaw), .step_time(step_time),
    .out_valid(out_valid), .out_stall(out_stall), .row(row), .column(column),
    .value(value), .saturated(saturated), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint atan_entry(input int i);
    longint t[24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
    return t[i];
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  task automatic rotate_angle(input logic signed [15:0] ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 131072;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI30) begin
      z -= PI30;
      flip = 1'b1;
    end else if (z < -HALF_PI30) begin
      z += PI30;
      flip = 1'b1;
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic void add_entry(input int r, input int c, input longint v, input bit sat);
    entry_t e;
    if (v > VMAX) begin
      v = VMAX; sat = 1'b1;
    end
    if (v < VMIN) begin
      v = VMIN; sat = 1'b1;
    end
    entry_index++;
    e.row = r[3:0];
    e.col = c[3:0];
    e.value = v[VW-1:0];
    e.sat = sat;
    e.last = (entry_index == 28);
    entries_due.push_back(e);
  endfunction

  function automatic void add_q30(input int r, input int c, input longint q);
    add_entry(r, c, round_shift(q, 14), 1'b0);
  endfunction

  // Entries divided by cos(pitch); a zero cosine clips by the sign of the numerator.
  function automatic void add_secant(input int r, input int c, input longint n, input longint cp);
    if (cp == 0) begin
      if (n == 0) add_entry(r, c, 0, 1'b0);
      else add_entry(r, c, n > 0 ? VMAX : VMIN, 1'b1);
    end else begin
      add_entry(r, c, (n * 65536) / cp, 1'b0);
    end
  endfunction

  function automatic void add_position_row(input int r, input longint v0, input longint v1,
                                           input longint v2, input longint dt);
    add_q30(r, 6, v0);
    add_q30(r, 7, v1);
    add_q30(r, 8, v2);
    add_q30(r, 12, (v0 * dt + (64'sd1 <<< 30)) >>> 31);
    add_q30(r, 13, (v1 * dt + (64'sd1 <<< 30)) >>> 31);
    add_q30(r, 14, (v2 * dt + (64'sd1 <<< 30)) >>> 31);
  endfunction

  task automatic predict_matrix(input logic signed [15:0] r_in, input logic signed [15:0] p_in,
                                input logic signed [15:0] y_in, input logic [15:0] t_in);
    longint sr, cr, sp, cp, sy, cy, dt, spsr, spcr;
    rotate_angle(r_in, sr, cr);
    rotate_angle(p_in, sp, cp);
    rotate_angle(y_in, sy, cy);
    dt = longint'(t_in) * 16384;
    entry_index = 0;
    spsr = qmul(sp, sr);
    spcr = qmul(sp, cr);
    add_position_row(0, qmul(qmul(cy, cp), dt),
                     qmul(qmul(cy, spsr) - qmul(sy, cr), dt),
                     qmul(qmul(cy, spcr) + qmul(sy, sr), dt), dt);
    add_position_row(1, qmul(qmul(sy, cp), dt),
                     qmul(qmul(sy, spsr) + qmul(cy, cr), dt),
                     qmul(qmul(sy, spcr) - qmul(cy, sr), dt), dt);
    add_position_row(2, qmul(-sp, dt), qmul(qmul(cp, sr), dt), qmul(qmul(cp, cr), dt), dt);
    add_q30(3, 9, dt);
    add_secant(3, 10, qmul(spsr, dt), cp);
    add_secant(3, 11, qmul(spcr, dt), cp);
    add_q30(4, 10, qmul(cr, dt));
    add_q30(4, 11, qmul(-sr, dt));
    add_secant(5, 10, qmul(sr, dt), cp);
    add_secant(5, 11, qmul(cr, dt), cp);
    add_q30(6, 12, dt);
    add_q30(7, 13, dt);
    add_q30(8, 14, dt);
  endtask

  // Transfers are sampled here at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    entry_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_matrix(roll, pitch, yaw, step_time);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        entries_seen++;
        if (saturated) sat_seen++;
        if (entries_due.size() == 0) begin
          $display("%0t: unexpected entry (%0d,%0d) value %0d", $time, row, column, value);
          mismatches++;
        end else begin
          e = entries_due.pop_front();
          if (row !== e.row || column !== e.col || value !== e.value ||
              saturated !== e.sat || last !== e.last) begin
            $display("%0t: expected (%0d,%0d) %0d sat %0b last %0b, got (%0d,%0d) %0d sat %0b last %0b",
                     $time, e.row, e.col, e.value, e.sat, e.last,
                     row, column, value, saturated, last);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver stalls come in bursts, counted down at each falling edge.
  always @(negedge clk) begin
    if (calm || rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 5);
      out_stall <= 1'b1;
    end
  end

  task automatic send_item(input logic signed [15:0] r_in, input logic signed [15:0] p_in,
                           input logic signed [15:0] y_in, input logic [15:0] t_in);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    roll <= r_in;
    pitch <= p_in;
    yaw <= y_in;
    step_time <= t_in;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] p;
    int known_base;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) begin
      send_item(directed[i].roll, directed[i].pitch, directed[i].yaw, directed[i].dt);
      // Rows whose entries are obvious get their typed values in place of the prediction.
      known_base = entries_due.size() - 28;
      if (directed[i].known == ALL_ZERO) begin
        for (int k = 0; k < 28; k++) begin
          entries_due[known_base + k].value = '0;
          entries_due[known_base + k].sat = 1'b0;
        end
      end else if (directed[i].known == STEP_ENTRIES) begin
        entries_due[known_base + 18].value = VW'(directed[i].dt);
        entries_due[known_base + 25].value = VW'(directed[i].dt);
        entries_due[known_base + 26].value = VW'(directed[i].dt);
        entries_due[known_base + 27].value = VW'(directed[i].dt);
      end
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: p = PITCH_UP + 16'($signed($urandom_range(0, 8)) - 4);
        1: p = -PITCH_UP + 16'($signed($urandom_range(0, 8)) - 4);
        default: p = 16'($urandom);
      endcase
      send_item(16'($urandom), p, 16'($urandom),
                ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
    end
    in_valid <= 1'b0;
    wait (entries_due.size() == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d attitude items, %0d matrix entries checked, %0d of them clipped.",
             items_taken, entries_seen, sat_seen);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: run did not finish in time", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
